/* src/spq_pkg.sv */
// Shared types, sizes and codes for the sorted priority queue.
package spq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ID_W   = 16;
   localparam int PRIO_W = 8;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int OUT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_TOP  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_PRIO = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR       = 2'd3;

   localparam logic [ST_W-1:0] ST_DONE = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL = 2'd1;
   localparam logic [ST_W-1:0] ST_NONE = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // Per-cell load control; at most one member is set in a cycle.
   typedef struct packed {
      logic load_new;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

   // Per-cell compare of the stored priority against the broadcast key.
   typedef struct packed {
      logic gt;
      logic eq;
   } cell_flag_type;

   // Fits an entry count to the five-bit result fields.
   function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
      logic [CNT_W+OUT_W-1:0] wide;
      wide = {{OUT_W{1'b0}}, v};
      return wide[OUT_W-1:0];
   endfunction

endpackage

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: a row of cells and its sequencer.
//
// Channel   Direction  Ports                                            Transfer
// request   in         req_opcode, req_process_id, req_priority_req     start && !busy
// result    out        rsp_status, rsp_removed_count, rsp_entry_count   rsp_strobe
//
// An insert or a clear is finished at the edge that accepts it, and its result is
// shown in the following cycle; busy stays low, so one such request can transfer
// in every cycle. A removal of the highest priority on an empty table is handled
// the same way and never raises busy. Any other removal holds busy while the row
// shifts left by one place per cycle, one removed entry at a time, until a check
// finds no further match and the sequencer shows the result.
// Reset empties the table (the entry count goes to zero).
// Results cannot be stalled by the receiver; each appears for exactly one cycle.
module sorted_priority_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [spq_pkg::OP_W-1:0]    req_opcode,
   input  logic [spq_pkg::ID_W-1:0]    req_process_id,
   input  logic [spq_pkg::PRIO_W-1:0]  req_priority_req,
   output logic                        rsp_strobe,
   output logic [spq_pkg::ST_W-1:0]    rsp_status,
   output logic [spq_pkg::OUT_W-1:0]   rsp_removed_count,
   output logic [spq_pkg::OUT_W-1:0]   rsp_entry_count
);
   import spq_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_REMOVE = 1'b1;

   logic                 state_ff,   state_in;
   logic [CNT_W-1:0]     count_ff,   count_in;
   logic [CNT_W-1:0]     removed_ff, removed_in;
   logic [PRIO_W-1:0]    target_ff,  target_in;
   logic                 strobe_ff,  strobe_in;
   logic [ST_W-1:0]      status_ff,  status_in;
   logic [CNT_W-1:0]     rcount_ff,  rcount_in;
   logic [CNT_W-1:0]     ecount_ff,  ecount_in;

   entry_type            cell_entry [DEPTH];
   cell_flag_type        cell_flag  [DEPTH];
   cell_ctrl_type        cell_ctrl  [DEPTH];
   logic [DEPTH-1:0]     occupied;
   logic [DEPTH-1:0]     place;
   logic [DEPTH-1:0]     match;
   logic [DEPTH-1:0]     shift;
   entry_type            new_entry;
   logic [PRIO_W-1:0]    key;
   logic                 accept;
   logic                 full;
   logic                 any_match;
   logic                 do_insert;
   logic                 do_shift;
   logic [CNT_W-1:0]     tail_pos;
   logic [IDX_W-1:0]     tail_idx;

   assign accept    = start && !busy;
   assign busy      = (state_ff == S_REMOVE);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign new_entry = '{id: req_process_id, prio: req_priority_req};
   // While idle the cells compare against the incoming priority; during a
   // removal they compare against the latched target priority.
   assign key       = busy ? target_ff : req_priority_req;
   assign do_insert = accept && (req_opcode == OP_INSERT) && !full;
   assign any_match = |match;
   assign do_shift  = busy && any_match;
   assign tail_pos  = count_ff - CNT_W'(1);
   assign tail_idx  = tail_pos[IDX_W-1:0];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         entry_type left_e;
         entry_type right_e;

         assign occupied[gi] = (CNT_W'(gi) < count_ff);
         // The new entry lands ahead of the first cell that is empty or
         // holds a strictly larger priority, so equal priorities stay in order.
         assign place[gi]    = !occupied[gi] || cell_flag[gi].gt;
         assign match[gi]    = occupied[gi] && cell_flag[gi].eq;
         // All matches are contiguous in a sorted row, so everything from the
         // first match onward moves one place toward the head.
         assign shift[gi]    = occupied[gi] && (cell_flag[gi].eq || cell_flag[gi].gt);

         if (gi == 0) begin : g_head
            assign left_e = new_entry;
            assign cell_ctrl[gi].load_new  = do_insert && place[gi];
            assign cell_ctrl[gi].take_left = 1'b0;
         end else begin : g_body
            assign left_e = cell_entry[gi-1];
            assign cell_ctrl[gi].load_new  = do_insert && place[gi] && !place[gi-1];
            assign cell_ctrl[gi].take_left = do_insert && place[gi] && place[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign right_e = cell_entry[gi];
         end else begin : g_mid
            assign right_e = cell_entry[gi+1];
         end

         assign cell_ctrl[gi].take_right = do_shift && shift[gi];

         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[gi]),
            .key         (key),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[gi]),
            .flag        (cell_flag[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      target_in  = target_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      rcount_in  = rcount_ff;
      ecount_in  = ecount_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_INSERT: begin
                     strobe_in = 1'b1;
                     rcount_in = '0;
                     if (full) begin
                        status_in = ST_FULL;
                        ecount_in = count_ff;
                     end else begin
                        count_in  = count_ff + CNT_W'(1);
                        status_in = ST_DONE;
                        ecount_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE_TOP: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = ST_NONE;
                        rcount_in = '0;
                        ecount_in = '0;
                     end else begin
                        // The tail holds the largest priority present.
                        target_in  = cell_entry[tail_idx].prio;
                        removed_in = '0;
                        state_in   = S_REMOVE;
                     end
                  end
                  OP_REMOVE_PRIO: begin
                     target_in  = req_priority_req;
                     removed_in = '0;
                     state_in   = S_REMOVE;
                  end
                  OP_CLEAR: begin
                     strobe_in = 1'b1;
                     status_in = ST_DONE;
                     rcount_in = count_ff;
                     ecount_in = '0;
                     count_in  = '0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_REMOVE: begin
            if (any_match) begin
               count_in   = count_ff - CNT_W'(1);
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               strobe_in = 1'b1;
               status_in = (removed_ff == '0) ? ST_NONE : ST_DONE;
               rcount_in = removed_ff;
               ecount_in = count_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      target_ff  <= target_in;
      status_ff  <= status_in;
      rcount_ff  <= rcount_in;
      ecount_ff  <= ecount_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_count = to_out(rcount_ff);
   assign rsp_entry_count   = to_out(ecount_ff);

endmodule

/* src/spq_cell.sv */
// One slot of the sorted row: holds an entry and compares it with the key.
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic [spq_pkg::PRIO_W-1:0] key,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry,
   output spq_pkg::cell_flag_type flag
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      priority if (ctrl.load_new) begin
         entry_in = new_entry;
      end else if (ctrl.take_left) begin
         entry_in = left_entry;
      end else if (ctrl.take_right) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry   = entry_ff;
   assign flag.gt = (entry_ff.prio > key);
   assign flag.eq = (entry_ff.prio == key);

endmodule

/* src/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [spq_pkg::OP_W-1:0]    req_opcode,
   input logic                        rsp_strobe,
   input logic [spq_pkg::ST_W-1:0]    rsp_status,
   input logic [spq_pkg::OUT_W-1:0]   rsp_removed_count
);
   import spq_pkg::*;

   // Inserts and clears answer in the cycle after their transfer.
   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_INSERT || req_opcode == OP_CLEAR)
      |=> rsp_strobe)
      else $error("insert or clear did not answer in the next cycle");

   // A result is shown only once the sequencer is free again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while a removal is still running");

   // Refused inserts and empty removals report no removed entries.
   a_none_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_FULL || rsp_status == ST_NONE)
      |-> rsp_removed_count == '0)
      else $error("removed count nonzero on a refused or empty request");

   // A removal that takes entries away reports done.
   a_removed_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_removed_count != '0 |-> rsp_status == ST_DONE)
      else $error("entries removed but status is not done");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

/* test/sorted_priority_queue_test.sv */
// Testbench for the sorted priority queue: directed and random requests against a shadow table.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
   import spq_pkg::*;

   // One predicted result, tagged with the opcode that caused it for messages.
   typedef struct {
      logic [OP_W-1:0]  op;
      logic [ST_W-1:0]  status;
      logic [OUT_W-1:0] removed;
      logic [OUT_W-1:0] count;
   } reply_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_opcode;
   logic [ID_W-1:0]   req_process_id;
   logic [PRIO_W-1:0] req_priority_req;
   logic              rsp_strobe;
   logic [ST_W-1:0]   rsp_status;
   logic [OUT_W-1:0]  rsp_removed_count;
   logic [OUT_W-1:0]  rsp_entry_count;

   // Shadow copy of the table: the first held_count entries are valid and sorted.
   entry_type held [DEPTH];
   int        held_count;

   // Results that have been predicted and not yet seen, oldest first.
   reply_type replies_due[$];

   int errors;
   int idle_pct;
   int n_sent;
   int n_checked;
   int n_refused;
   int n_nothing_removed;
   int n_multi_removed;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_process_id    (req_process_id),
      .req_priority_req  (req_priority_req),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drops every held entry of the given priority, keeping the others in order.
   // Returns how many entries were dropped.
   function automatic int drop_priority(input logic [PRIO_W-1:0] p);
      int kept;
      int dropped;
      kept = 0;
      for (int i = 0; i < held_count; i++) begin
         if (held[i].prio != p) begin
            held[kept] = held[i];
            kept++;
         end
      end
      dropped = held_count - kept;
      held_count = kept;
      return dropped;
   endfunction

   // Applies one request to the shadow table and returns the result it must give.
   function automatic reply_type table_apply(input logic [OP_W-1:0]   op,
                                             input logic [ID_W-1:0]   id,
                                             input logic [PRIO_W-1:0] pr);
      reply_type r;
      int        pos;
      int        removed;
      r.op = op;
      r.status = ST_DONE;
      removed = 0;
      case (op)
         OP_INSERT: begin
            if (held_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // A new entry goes behind every entry of lower or equal priority.
               pos = 0;
               while (pos < held_count && held[pos].prio <= pr) pos++;
               for (int i = held_count; i > pos; i--) held[i] = held[i-1];
               held[pos].id = id;
               held[pos].prio = pr;
               held_count++;
            end
         end
         OP_REMOVE_TOP: begin
            // The highest priority present sits at the tail of the sorted table.
            if (held_count == 0) r.status = ST_NONE;
            else removed = drop_priority(held[held_count-1].prio);
         end
         OP_REMOVE_PRIO: begin
            removed = drop_priority(pr);
            if (removed == 0) r.status = ST_NONE;
         end
         default: begin
            // Clear always reports done, even when the table was already empty.
            removed = held_count;
            held_count = 0;
         end
      endcase
      r.removed = removed[OUT_W-1:0];
      r.count = held_count[OUT_W-1:0];
      return r;
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // Sends one request. Inputs change at the falling edge, and the transfer is
   // taken at the first rising edge where busy is low. Start stays high after
   // the transfer, so back-to-back requests never lower and raise it in one step.
   task automatic send_item(input logic [OP_W-1:0]   op,
                            input logic [ID_W-1:0]   id,
                            input logic [PRIO_W-1:0] pr);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_process_id <= id;
      req_priority_req <= pr;
      @(posedge clock);
      while (busy) @(posedge clock);
      replies_due.push_back(table_apply(op, id, pr));
      n_sent++;
   endtask

   // Checks every result against the oldest prediction, field by field, and
   // tallies the kinds of results for the summary.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (replies_due.size() == 0) begin
            flag_error($sformatf("result with nothing expected: status %0d removed %0d count %0d",
                                 rsp_status, rsp_removed_count, rsp_entry_count));
         end else begin
            want = replies_due.pop_front();
            n_checked++;
            if (want.status == ST_FULL) n_refused++;
            if (want.status == ST_NONE) n_nothing_removed++;
            if (want.removed > 1) n_multi_removed++;
            if (rsp_status !== want.status || rsp_removed_count !== want.removed ||
                rsp_entry_count !== want.count) begin
               flag_error($sformatf(
                  "op %0d: status %0d/%0d removed %0d/%0d count %0d/%0d (expected/actual)",
                  want.op, want.status, rsp_status, want.removed, rsp_removed_count,
                  want.count, rsp_entry_count));
            end
         end
      end
   end

   // Every removal and clear on an empty table, with both priority extremes.
   task automatic test_empty_table();
      send_item(OP_CLEAR, 16'h0000, 8'h00);
      send_item(OP_REMOVE_TOP, 16'hFFFF, 8'hFF);
      send_item(OP_REMOVE_PRIO, 16'h0000, 8'h00);
      send_item(OP_REMOVE_PRIO, 16'hFFFF, 8'hFF);
   endtask

   // Fills the table with extremes and repeated priorities, then tries one more insert.
   task automatic test_fill_to_full();
      logic [PRIO_W-1:0] prios [16];
      logic [ID_W-1:0]   id;
      prios = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd128, 8'd7, 8'd0, 8'd255,
                8'd1, 8'd254, 8'd7, 8'd64, 8'd0, 8'd255, 8'd200, 8'd7};
      for (int i = 0; i < DEPTH; i++) begin
         id = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         send_item(OP_INSERT, id, prios[i % 16]);
      end
      send_item(OP_INSERT, 16'hA5A5, 8'd0);
   endtask

   // Removals from the full table: a miss, multiple matches, the top groups, then a clear.
   task automatic test_directed_removals();
      send_item(OP_REMOVE_PRIO, 16'h0000, 8'd99);
      send_item(OP_REMOVE_PRIO, 16'h0000, 8'd7);
      send_item(OP_REMOVE_TOP, 16'h0000, 8'd0);
      send_item(OP_REMOVE_PRIO, 16'h0000, 8'd0);
      send_item(OP_REMOVE_TOP, 16'h0000, 8'd0);
      send_item(OP_CLEAR, 16'h0000, 8'd0);
   endtask

   // Random traffic. Priorities mostly come from a small pool so that equal
   // priorities and multi-entry removals are common; now and then a burst of
   // inserts fills the table and runs into the full case.
   task automatic test_random_traffic(input int pct, input int items);
      logic [PRIO_W-1:0] pool [4];
      logic [PRIO_W-1:0] pr;
      int                pick;
      int                sent;
      idle_pct = pct;
      pool[0] = 8'($urandom_range(0, 255));
      pool[1] = 8'($urandom_range(0, 255));
      pool[2] = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(0, 255));
      pool[3] = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         pr = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 3)]
                                           : 8'($urandom_range(0, 255));
         if (pick < 4) begin
            while (held_count < DEPTH) begin
               send_item(OP_INSERT, 16'($urandom_range(0, 65535)), pool[$urandom_range(0, 3)]);
               sent++;
            end
            send_item(OP_INSERT, 16'($urandom_range(0, 65535)), pr);
            sent++;
         end else if (pick < 58) begin
            send_item(OP_INSERT, 16'($urandom_range(0, 65535)), pr);
            sent++;
         end else if (pick < 72) begin
            send_item(OP_REMOVE_TOP, 16'($urandom_range(0, 65535)), pr);
            sent++;
         end else if (pick < 95) begin
            // Mostly aim at a priority that is really held.
            if (held_count > 0 && $urandom_range(0, 99) < 70)
               pr = held[$urandom_range(0, held_count - 1)].prio;
            send_item(OP_REMOVE_PRIO, 16'($urandom_range(0, 65535)), pr);
            sent++;
         end else begin
            send_item(OP_CLEAR, 16'($urandom_range(0, 65535)), pr);
            sent++;
         end
      end
   endtask

   initial begin
      int guard;
      errors = 0;
      idle_pct = 0;
      n_sent = 0;
      n_checked = 0;
      n_refused = 0;
      n_nothing_removed = 0;
      n_multi_removed = 0;
      held_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_INSERT;
      req_process_id = '0;
      req_priority_req = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_to_full();
      test_directed_removals();
      test_random_traffic(0, 180);
      test_random_traffic(55, 180);
      test_random_traffic(18, 180);
      test_random_traffic(0, 160);

      @(negedge clock);
      start <= 1'b0;

      // A removal can keep the block busy, so wait for every result still due.
      guard = 0;
      while (replies_due.size() > 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DEPTH + 4) @(posedge clock);
      if (replies_due.size() > 0)
         flag_error($sformatf("%0d results never arrived", replies_due.size()));

      $display("Sent %0d requests and checked %0d results over four random phases.",
               n_sent, n_checked);
      $display("Refused inserts: %0d, empty removals: %0d, multi-entry removals: %0d.",
               n_refused, n_nothing_removed, n_multi_removed);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches in total.", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #5_000_000;
      $display("Timed out waiting for the block.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
test/sorted_priority_queue_test.sv
